// File: sv/assert_macros.svh
// Assertion helpers, off in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/cdd_pkg.sv
`default_nettype none
package cdd_pkg;
  localparam int DenW = 20;
  localparam int CntW = 16;
  localparam int AmtW = 32;
  localparam int StW  = 3;

  localparam logic [StW-1:0] ST_DEP_OK = 3'd0;
  localparam logic [StW-1:0] ST_PAID   = 3'd1;
  localparam logic [StW-1:0] ST_REJECT = 3'd2;
  localparam logic [StW-1:0] ST_FULL   = 3'd3;
  localparam logic [StW-1:0] ST_SHORT  = 3'd4;

  localparam logic OP_DEPOSIT  = 1'b0;
  localparam logic OP_WITHDRAW = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DEP, S_WCHK, S_WMOD, S_REJ, S_SCAN, S_WDIV, S_MUL, S_UPD, S_FIN
  } state_t;

  typedef struct packed {
    logic            ins;
    logic            add;
    logic            dec;
    logic [DenW-1:0] denom;
    logic [CntW-1:0] notes;
  } cmd_t;
endpackage
`default_nettype wire

// File: sv/cdd_cell.sv
`default_nettype none
module cdd_cell
  import cdd_pkg::*;
(
  input  wire logic            clk,
  input  wire cmd_t            cmd,
  input  wire logic            occ,
  input  wire logic            sel,
  input  wire logic            left_lt,
  input  wire logic [DenW-1:0] left_den,
  input  wire logic [CntW-1:0] left_cnt,
  output logic [DenW-1:0]      den,
  output logic [CntW-1:0]      cnt,
  output logic                 lt,
  output logic                 eq
);
  logic [CntW:0] sum;

  assign lt  = occ && (den < cmd.denom);
  assign eq  = occ && (den == cmd.denom);
  assign sum = {1'b0, cnt} + {1'b0, cmd.notes};

  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      if (left_lt) begin
        den <= cmd.denom;
        cnt <= cmd.notes;
      end else begin
        den <= left_den;
        cnt <= left_cnt;
      end
    end else if (cmd.add && eq) begin
      cnt <= sum[CntW] ? {CntW{1'b1}} : sum[CntW-1:0];
    end else if (cmd.dec && sel) begin
      cnt <= cnt - cmd.notes;
    end
  end
endmodule
`default_nettype wire

// File: sv/cdd_div.sv
`default_nettype none
module cdd_div
  import cdd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [AmtW-1:0] dividend,
  input  wire logic [DenW-1:0] divisor,
  output logic                 done,
  output logic [AmtW-1:0]      quotient,
  output logic [DenW-1:0]      remainder
);
  localparam int StepW = $clog2(AmtW + 1);

  logic             busy;
  logic [StepW-1:0] steps;
  logic [DenW-1:0]  dvs;
  logic [DenW:0]    sh;
  logic             fits;

  assign sh   = {remainder, quotient[AmtW-1]};
  assign fits = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        steps     <= StepW'(AmtW);
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (busy) begin
        remainder <= fits ? DenW'(sh - {1'b0, dvs}) : sh[DenW-1:0];
        quotient  <= {quotient[AmtW-2:0], fits};
        steps     <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/cash_dispense_denomination_table.sv
// Deposit: result word loaded in S_DEP once the output is free; next word accepted
// after the return to S_IDLE. Withdraw: S_WCHK checks table and amount, S_WMOD the
// divisibility by the smallest entry, else a reject word; entries then go largest
// first, paid via S_WDIV, S_MUL, S_UPD or skipped, then a final word in S_FIN.
// The 32-step divider is shared. One item at a time; output stalls add cycles.
// Synchronous active-high reset empties the table and drops pending words.
`default_nettype none
`include "assert_macros.svh"
module cash_dispense_denomination_table
  import cdd_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            opcode,
  input  wire logic [DenW-1:0] denomination,
  input  wire logic [CntW-1:0] note_count,
  input  wire logic [AmtW-1:0] amount,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [StW-1:0]       status,
  output logic [DenW-1:0]      paid_denomination,
  output logic [CntW-1:0]      paid_notes,
  output logic [AmtW-1:0]      remaining_amount,
  output logic                 last
);
  localparam int PW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;
  logic [UW-1:0]   used;
  logic [DenW-1:0] den_r;
  logic [CntW-1:0] cnt_r;
  logic [AmtW-1:0] amt_r, rem;
  logic [PW-1:0]   ptr;
  logic [CntW-1:0] n_r;
  logic [DenW+CntW-1:0] prod;
  logic            pend_v;
  logic [DenW-1:0] pend_den;
  logic [CntW-1:0] pend_notes;
  logic [AmtW-1:0] pend_rem;

  logic [DenW-1:0] cden [TABLE_DEPTH];
  logic [CntW-1:0] ccnt [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt, eq;
  cmd_t cmd;

  logic match, full, out_free, out_load, div_start, div_done;
  logic [StW-1:0]  o_st;
  logic [DenW-1:0] o_den;
  logic [CntW-1:0] o_notes;
  logic [AmtW-1:0] o_rem;
  logic            o_last;
  logic [AmtW-1:0] dvd, quo;
  logic [DenW-1:0] dvs, dmod;
  logic [DenW-1:0] rd_den;
  logic [CntW-1:0] rd_cnt;

  genvar i;
  generate
    for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        cdd_cell u_cell (
          .clk(clk), .cmd(cmd), .occ(UW'(i) < used), .sel(ptr == PW'(i)),
          .left_lt(1'b1), .left_den(cden[0]), .left_cnt(ccnt[0]),
          .den(cden[i]), .cnt(ccnt[i]), .lt(lt[i]), .eq(eq[i])
        );
      end else begin : g_rest
        cdd_cell u_cell (
          .clk(clk), .cmd(cmd), .occ(UW'(i) < used), .sel(ptr == PW'(i)),
          .left_lt(lt[i-1]), .left_den(cden[i-1]), .left_cnt(ccnt[i-1]),
          .den(cden[i]), .cnt(ccnt[i]), .lt(lt[i]), .eq(eq[i])
        );
      end
    end
  endgenerate

  cdd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(quo), .remainder(dmod)
  );

  assign match    = |eq;
  assign full     = used == UW'(TABLE_DEPTH);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;
  assign rd_den   = cden[ptr];
  assign rd_cnt   = ccnt[ptr];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = (opcode == OP_DEPOSIT) ? S_DEP : S_WCHK;
      S_DEP:  if (out_free) state_next = S_IDLE;
      S_WCHK: begin
        if (used == '0 || amt_r == '0 || amt_r < AmtW'(cden[0])) state_next = S_REJ;
        else state_next = S_WMOD;
      end
      S_WMOD: if (div_done) state_next = (dmod != '0) ? S_REJ : S_SCAN;
      S_REJ:  if (out_free) state_next = S_IDLE;
      S_SCAN: begin
        if (rem == '0) state_next = S_FIN;
        else if (AmtW'(rd_den) > rem || rd_cnt == '0)
          state_next = (ptr == '0) ? S_FIN : S_SCAN;
        else state_next = S_WDIV;
      end
      S_WDIV: if (div_done) state_next = S_MUL;
      S_MUL:  state_next = S_UPD;
      S_UPD:  if (!pend_v || out_free) state_next = (ptr == '0) ? S_FIN : S_SCAN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_load  = 1'b0;
    o_st      = ST_DEP_OK;
    o_den     = '0;
    o_notes   = '0;
    o_rem     = '0;
    o_last    = 1'b1;
    cmd       = '{ins: 1'b0, add: 1'b0, dec: 1'b0, denom: den_r, notes: cnt_r};
    div_start = 1'b0;
    dvd       = rem;
    dvs       = rd_den;
    case (state)
      S_DEP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (den_r == '0) o_st = ST_REJECT;
          else if (!match && full) o_st = ST_FULL;
          cmd.add = den_r != '0 && match;
          cmd.ins = den_r != '0 && !match && !full;
        end
      end
      S_WCHK: begin
        dvd       = amt_r;
        dvs       = cden[0];
        div_start = state_next == S_WMOD;
      end
      S_REJ: begin
        out_load = out_free;
        o_st     = ST_REJECT;
        o_rem    = amt_r;
      end
      S_SCAN: div_start = state_next == S_WDIV;
      S_UPD: begin
        if (!pend_v || out_free) begin
          out_load  = pend_v;
          cmd.dec   = 1'b1;
          cmd.notes = n_r;
        end
        o_st    = ST_PAID;
        o_den   = pend_den;
        o_notes = pend_notes;
        o_rem   = pend_rem;
        o_last  = 1'b0;
      end
      S_FIN: begin
        out_load = out_free;
        o_st     = (rem != '0) ? ST_SHORT : ST_PAID;
        o_rem    = rem;
        if (pend_v) begin
          o_den   = pend_den;
          o_notes = pend_notes;
        end else begin
          o_st = ST_SHORT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cmd.ins) used <= used + 1'b1;
      if (state == S_UPD && state_next != S_UPD) pend_v <= 1'b1;
      if (state == S_FIN && out_free) pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      den_r <= denomination;
      cnt_r <= note_count;
      amt_r <= amount;
      rem   <= amount;
      ptr   <= PW'(used - 1'b1);
    end
    if (state == S_SCAN && state_next == S_SCAN) ptr <= ptr - 1'b1;
    if (state == S_WDIV && div_done)
      n_r <= (quo > AmtW'(rd_cnt)) ? rd_cnt : quo[CntW-1:0];
    if (state == S_MUL) prod <= n_r * rd_den;
    if (state == S_UPD && state_next != S_UPD) begin
      rem        <= rem - prod[AmtW-1:0];
      pend_den   <= rd_den;
      pend_notes <= n_r;
      pend_rem   <= rem - prod[AmtW-1:0];
      if (ptr != '0) ptr <= ptr - 1'b1;
    end
    if (out_load) begin
      status            <= o_st;
      paid_denomination <= o_den;
      paid_notes        <= o_notes;
      remaining_amount  <= o_rem;
      last              <= o_last;
    end
  end

  `ASSERT_ALWAYS(a_used_bound, clk, rst, used <= UW'(TABLE_DEPTH))
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, state != S_IDLE)
  `ASSERT_IMPL(a_paid_last, clk, rst, out_valid && last && status == ST_PAID, remaining_amount == '0)
endmodule
`default_nettype wire

// File: tb/cash_dispense_denomination_table_tb.sv
`default_nettype none
module cash_dispense_denomination_table_tb;
  import cdd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 8;

  typedef struct {
    logic [StW-1:0]  st;
    logic [DenW-1:0] den;
    logic [CntW-1:0] notes;
    logic [AmtW-1:0] rem;
    logic            lst;
  } payout_t;

  class till_scoreboard;
    logic [DenW-1:0] den_tab[Depth];
    logic [CntW-1:0] cnt_tab[Depth];
    int used;
    payout_t due[$];
    int errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void push(logic [StW-1:0] st, logic [DenW-1:0] d, logic [CntW-1:0] n,
                       logic [AmtW-1:0] r, logic l);
      payout_t p;
      p.st = st; p.den = d; p.notes = n; p.rem = r; p.lst = l;
      due.push_back(p);
    endfunction

    function logic [StW-1:0] deposit(logic [DenW-1:0] d, logic [CntW-1:0] n);
      int pos;
      int room;
      pos = 0;
      if (d == 0) return ST_REJECT;
      while (pos < used && den_tab[pos] < d) pos++;
      if (pos < used && den_tab[pos] == d) begin
        room = 65535 - cnt_tab[pos];
        cnt_tab[pos] = cnt_tab[pos] + ((n > room) ? room : n);
        return ST_DEP_OK;
      end
      if (used >= Depth) return ST_FULL;
      for (int j = used; j > pos; j--) begin
        den_tab[j] = den_tab[j-1];
        cnt_tab[j] = cnt_tab[j-1];
      end
      den_tab[pos] = d;
      cnt_tab[pos] = n;
      used++;
      return ST_DEP_OK;
    endfunction

    function void note_word(logic op, logic [DenW-1:0] d, logic [CntW-1:0] n,
                            logic [AmtW-1:0] a);
      logic [AmtW-1:0] rem;
      longint q, k;
      int paid;
      if (op == OP_DEPOSIT) begin
        push(deposit(d, n), 0, 0, 0, 1'b1);
        return;
      end
      if (used == 0 || a == 0 || a < den_tab[0] || (a % den_tab[0]) != 0) begin
        push(ST_REJECT, 0, 0, a, 1'b1);
        return;
      end
      rem = a;
      paid = 0;
      for (int i = used - 1; i >= 0 && rem != 0; i--) begin
        if (den_tab[i] > rem || cnt_tab[i] == 0) continue;
        q = rem / den_tab[i];
        k = (q < cnt_tab[i]) ? q : cnt_tab[i];
        cnt_tab[i] = cnt_tab[i] - k;
        rem = rem - k * den_tab[i];
        push(ST_PAID, den_tab[i], k, rem, 1'b0);
        paid++;
      end
      if (paid == 0) push(ST_SHORT, 0, 0, rem, 1'b1);
      else begin
        due[$].lst = 1'b1;
        if (rem != 0) due[$].st = ST_SHORT;
      end
    endfunction

    function void check_word(logic [StW-1:0] st, logic [DenW-1:0] d, logic [CntW-1:0] n,
                             logic [AmtW-1:0] r, logic l);
      payout_t p;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: st=%0d den=%0d notes=%0d rem=%0d last=%0b",
                                   st, d, n, r, l);
        return;
      end
      p = due.pop_front();
      if (st !== p.st || d !== p.den || n !== p.notes || r !== p.rem || l !== p.lst) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d den=%0d notes=%0d rem=%0d last=%0b, got st=%0d den=%0d notes=%0d rem=%0d last=%0b",
                   p.st, p.den, p.notes, p.rem, p.lst, st, d, n, r, l);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_DEPOSIT;
  logic [DenW-1:0] denomination = '0;
  logic [CntW-1:0] note_count = '0;
  logic [AmtW-1:0] amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [StW-1:0] status;
  logic [DenW-1:0] paid_denomination;
  logic [CntW-1:0] paid_notes;
  logic [AmtW-1:0] remaining_amount;
  logic last;

  till_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  cash_dispense_denomination_table #(.TABLE_DEPTH(Depth)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .denomination(denomination), .note_count(note_count),
    .amount(amount), .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .paid_denomination(paid_denomination), .paid_notes(paid_notes),
    .remaining_amount(remaining_amount), .last(last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word(status, paid_denomination, paid_notes, remaining_amount, last);
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (stall_cnt % 7) < 4;
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic send_word(logic op, logic [DenW-1:0] d, logic [CntW-1:0] n,
                           logic [AmtW-1:0] a);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    opcode <= op;
    denomination <= d;
    note_count <= n;
    amount <= a;
    do @(posedge clk); while (in_stall);
    sb.note_word(op, d, n, a);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DenW-1:0] pick_denom();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 2;
      2: return 5;
      3: return 10;
      4: return 20;
      5: return 50;
      6: return 100;
      7: return 500;
      8: return 20'hFFFFF;
      default: return DenW'($urandom_range(1, 20'hFFFFF));
    endcase
  endfunction

  initial begin
    logic [DenW-1:0] d;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(OP_WITHDRAW, 0, 0, 100);
    send_word(OP_DEPOSIT, 0, 7, 0);
    send_word(OP_DEPOSIT, 20, 0, 0);
    send_word(OP_WITHDRAW, 0, 0, 40);
    send_word(OP_DEPOSIT, 5, 3, 32'hFFFFFFFF);
    send_word(OP_DEPOSIT, 50, 16'hFFFF, 0);
    send_word(OP_DEPOSIT, 50, 10, 0);
    send_word(OP_DEPOSIT, 10, 4, 0);
    send_word(OP_WITHDRAW, 20'hFFFFF, 16'hFFFF, 0);
    send_word(OP_WITHDRAW, 0, 0, 3);
    send_word(OP_WITHDRAW, 0, 0, 7);
    send_word(OP_WITHDRAW, 0, 0, 85);
    send_word(OP_WITHDRAW, 0, 0, 32'hFFFFFFFF);
    send_word(OP_DEPOSIT, 20'hFFFFF, 1, 0);
    send_word(OP_WITHDRAW, 0, 0, 1048575 + 35);
    drain();
    for (int i = 0; i < 85; i++) begin
      if (i == 40) drain();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          d = pick_denom();
          send_word(OP_DEPOSIT, d, CntW'($urandom_range(0, 60)), $urandom);
        end
        4: send_word(OP_DEPOSIT, DenW'($urandom), CntW'($urandom), $urandom);
        5: send_word(OP_WITHDRAW, DenW'($urandom), CntW'($urandom), $urandom);
        default: begin
          d = (sb.used > 0) ? sb.den_tab[0] : 5;
          send_word(OP_WITHDRAW, DenW'($urandom), CntW'($urandom),
                    AmtW'(d * $urandom_range(1, 300)));
        end
      endcase
    end
    drain();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
